FILE: sv/smpq_pkg.sv
package smpq_pkg;

    localparam int WEIGHT_W = 16;
    localparam int TAG_W    = 16;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef logic [WEIGHT_W-1:0] weight_t;
    typedef logic [TAG_W-1:0]    tag_t;

    // Broadcast to every cell for the transaction in flight
    typedef struct packed {
        logic    insert;
        logic    remove;
        weight_t weight;
        tag_t    tag;
    } cell_ctrl_t;

endpackage

FILE: sv/smpq_cell.sv
module smpq_cell
    import smpq_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  logic       occupied,
    input  logic       force_keep,
    input  logic       left_keep,
    input  weight_t    left_weight,
    input  tag_t       left_tag,
    input  weight_t    right_weight,
    input  tag_t       right_tag,
    output logic       keep,
    output weight_t    weight,
    output tag_t       tag
);

    weight_t weight_reg;
    weight_t weight_next;
    tag_t    tag_reg;
    tag_t    tag_next;

    // Stored entries smaller than the new weight stay put; the list is sorted,
    // so the keep flags form a prefix along the chain.
    assign keep   = force_keep | (occupied & (weight_reg < ctrl.weight));
    assign weight = weight_reg;
    assign tag    = tag_reg;

    always_comb
    begin
        weight_next = weight_reg;
        tag_next    = tag_reg;
        if (ctrl.insert && !keep)
        begin
            if (left_keep)
            begin
                // first cell past the kept prefix takes the new item
                weight_next = ctrl.weight;
                tag_next    = ctrl.tag;
            end
            else
            begin
                weight_next = left_weight;
                tag_next    = left_tag;
            end
        end
        else if (ctrl.remove)
        begin
            weight_next = right_weight;
            tag_next    = right_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        weight_reg <= weight_next;
        tag_reg    <= tag_next;
    end

endmodule

FILE: sv/sorted_min_priority_queue_unit.sv
// Sorted minimum priority queue, a chain of QUEUE_DEPTH cells kept in
// ascending weight order with the head in cell 0.
//
// Command channel: drive operation, item_weight and item_tag with start high;
// the transaction is accepted at a rising edge where start is high and busy is
// low. busy stays low, so a new command may follow every cycle.
// Result channel: in the cycle after acceptance, done pulses for exactly one
// cycle with status, popped_weight, popped_tag and entry_count. The receiver
// cannot stall; it must capture the result in that cycle.
// Throughput is 1 transaction per cycle: every cell compares its weight
// against the incoming one in parallel and shifts toward or away from the
// head in the same edge.
// An insert into a full queue is dropped with status 1; a remove from an
// empty queue returns status 2 with zero weight and tag.
// Reset clears the occupancy count and the result strobe; cell contents are
// left as they are and are never read until written.
module sorted_min_priority_queue_unit
    import smpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                operation,
    input  logic [WEIGHT_W-1:0] item_weight,
    input  logic [TAG_W-1:0]    item_tag,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic [WEIGHT_W-1:0] popped_weight,
    output logic [TAG_W-1:0]    popped_tag,
    output logic [COUNT_W-1:0]  entry_count
);

    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

    logic [OCC_W-1:0]    occ_reg;
    logic [OCC_W-1:0]    occ_next;
    logic                done_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    weight_t             pw_reg;
    weight_t             pw_next;
    tag_t                pt_reg;
    tag_t                pt_next;

    logic       accept;
    logic       full;
    logic       empty;
    logic       head_eq;
    cell_ctrl_t ctrl;

    weight_t    cell_weight [QUEUE_DEPTH];
    tag_t       cell_tag    [QUEUE_DEPTH];
    logic       cell_keep   [QUEUE_DEPTH];

    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign full    = (occ_reg == OCC_W'(QUEUE_DEPTH));
    assign empty   = (occ_reg == '0);
    assign head_eq = !empty && (cell_weight[0] == item_weight);

    always_comb
    begin
        ctrl.insert = accept && (operation == OP_INSERT) && !full;
        ctrl.remove = accept && (operation == OP_REMOVE) && !empty;
        ctrl.weight = item_weight;
        ctrl.tag    = item_tag;
    end

    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin : g_cell
            logic    lkeep;
            weight_t lweight;
            tag_t    ltag;
            weight_t rweight;
            tag_t    rtag;
            logic    fkeep;

            if (i == 0)
            begin : g_head
                assign lkeep   = 1'b1;
                assign lweight = item_weight;
                assign ltag    = item_tag;
                // a weight equal to the head goes in behind it
                assign fkeep   = head_eq;
            end
            else
            begin : g_body
                assign lkeep   = cell_keep[i-1];
                assign lweight = cell_weight[i-1];
                assign ltag    = cell_tag[i-1];
                assign fkeep   = 1'b0;
            end

            if (i == QUEUE_DEPTH - 1)
            begin : g_tail
                assign rweight = cell_weight[i];
                assign rtag    = cell_tag[i];
            end
            else
            begin : g_link
                assign rweight = cell_weight[i+1];
                assign rtag    = cell_tag[i+1];
            end

            smpq_cell u_cell (
                .clk          (clk),
                .ctrl         (ctrl),
                .occupied     (OCC_W'(i) < occ_reg),
                .force_keep   (fkeep),
                .left_keep    (lkeep),
                .left_weight  (lweight),
                .left_tag     (ltag),
                .right_weight (rweight),
                .right_tag    (rtag),
                .keep         (cell_keep[i]),
                .weight       (cell_weight[i]),
                .tag          (cell_tag[i])
            );
        end
    endgenerate

    always_comb
    begin
        occ_next    = occ_reg;
        status_next = ST_DONE;
        pw_next     = '0;
        pt_next     = '0;
        if (operation == OP_INSERT)
        begin
            if (full)
                status_next = ST_FULL;
            else
                occ_next = occ_reg + OCC_W'(1);
        end
        else
        begin
            if (empty)
                status_next = ST_EMPTY;
            else
            begin
                occ_next = occ_reg - OCC_W'(1);
                pw_next  = cell_weight[0];
                pt_next  = cell_tag[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
                occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            pw_reg     <= pw_next;
            pt_reg     <= pt_next;
        end
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign popped_weight = pw_reg;
    assign popped_tag    = pt_reg;

    generate
        if (OCC_W >= COUNT_W)
        begin : g_cnt_trunc
            assign entry_count = occ_reg[COUNT_W-1:0];
        end
        else
        begin : g_cnt_ext
            assign entry_count = {{(COUNT_W-OCC_W){1'b0}}, occ_reg};
        end
    endgenerate

endmodule
